@@ hdl/mwrc_pkg.sv @@
`default_nettype none

package mwrc_pkg;

   localparam logic [1:0] CMD_NONE      = 2'd0;
   localparam logic [1:0] CMD_READ_WORD = 2'd1;
   localparam logic [1:0] CMD_READ_MAC  = 2'd2;
   localparam logic [1:0] CMD_READ_ID   = 2'd3;

   localparam logic [2:0] READ_OPCODE = 3'b110;
   localparam int OPCODE_BITS = 3;
   localparam int DATA_BITS   = 16;

   localparam logic [15:0] HALF_PERIOD_RESET = 16'd16;

   typedef struct packed {
      logic [1:0] command;
      logic [5:0] address;
      logic       data_out_pin;
   } req_type;

   typedef struct packed {
      logic        program_mode;
      logic        chip_select;
      logic        serial_clock;
      logic        data_in_pin;
      logic        busy_res;
      logic        word_valid;
      logic [15:0] word_value;
      logic [5:0]  word_number;
      logic        sequence_done;
      logic        sequence_ok;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/microwire_eeprom_read_controller_top.sv @@
// Read controller for a three-wire serial EEPROM.
// Each request transaction is one tick of the controller: it carries an
// optional command, a word address and the sampled data-out pin. Each
// request produces exactly one response transaction holding the pin levels
// to drive for that tick and the status flags (busy, word read, done, ok).
// Commands are taken only while no sequence runs and are ignored otherwise.
// The serial clock half period is set through the csr port and takes effect
// at the next tick; writes are expected while no transaction is in flight.
// A request enters an input register and is processed into the output
// register when that register is free, so its response is presented from
// the output register. One transaction per cycle is sustained while the
// receiver does not stall; the limit is the single state update per tick.
// When the receiver stalls, the held response does not change, the pending
// request waits in the input register, and req_stall rises once that
// register is occupied. Reset is synchronous: the sequencer returns to idle,
// both registers empty, and the half period returns to 16 ticks.
`default_nettype none

module microwire_eeprom_read_controller_top #(
   parameter int ADDRESS_BITS   = 6,
   parameter int MAC_FIRST_WORD = 7,
   parameter int MAC_WORDS      = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire mwrc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output mwrc_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write,
   input  wire logic [15:0]       csr_wdata
);
   import mwrc_pkg::*;

   logic [15:0] half_period_ff;
   logic        in_valid_ff;
   req_type     in_data_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;

   logic    out_free;
   logic    step;
   rsp_type seq_rsp;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   mwrc_seq #(
      .ADDRESS_BITS   (ADDRESS_BITS),
      .MAC_FIRST_WORD (MAC_FIRST_WORD),
      .MAC_WORDS      (MAC_WORDS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .half_period (half_period_ff),
      .req_item    (in_data_ff),
      .rsp_item    (seq_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         half_period_ff <= HALF_PERIOD_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) half_period_ff <= csr_wdata;
         if (!req_stall) in_valid_ff <= req_valid;
         if (out_free) rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) in_data_ff <= req_data;
      if (step) rsp_data_ff <= seq_rsp;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hdl/mwrc_seq.sv @@
`default_nettype none

module mwrc_seq #(
   parameter int ADDRESS_BITS   = 6,
   parameter int MAC_FIRST_WORD = 7,
   parameter int MAC_WORDS      = 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [15:0]      half_period,
   input  wire mwrc_pkg::req_type req_item,
   output mwrc_pkg::rsp_type     rsp_item
);
   import mwrc_pkg::*;

   localparam int FRAME_W = OPCODE_BITS + ADDRESS_BITS;

   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_ENTER_HI = 4'd1,
      PH_ENTER_LO = 4'd2,
      PH_SEND_HI  = 4'd3,
      PH_SEND_LO  = 4'd4,
      PH_RECV_HI  = 4'd5,
      PH_RECV_LO  = 4'd6,
      PH_CLOSE_HI = 4'd7,
      PH_CLOSE_LO = 4'd8,
      PH_FINAL    = 4'd9
   } phase_type;

   phase_type               phase_ff, phase_in;
   logic [15:0]             tick_count_ff, tick_count_in;
   logic [4:0]              bit_count_ff, bit_count_in;
   logic [15:0]             shift_word_ff, shift_word_in;
   logic [1:0]              words_left_ff, words_left_in;
   logic [ADDRESS_BITS-1:0] current_address_ff, current_address_in;
   logic [1:0]              active_command_ff, active_command_in;
   logic                    first_word_zero_ff, first_word_zero_in;

   logic [15:0] hp;
   logic [15:0] tick_inc;
   logic        period_end;
   logic [15:0] frame;
   logic [3:0]  pos;
   rsp_type     rsp;

   always_comb begin
      phase_in           = phase_ff;
      tick_count_in      = tick_count_ff;
      bit_count_in       = bit_count_ff;
      shift_word_in      = shift_word_ff;
      words_left_in      = words_left_ff;
      current_address_in = current_address_ff;
      active_command_in  = active_command_ff;
      first_word_zero_in = first_word_zero_ff;
      rsp                = '0;

      hp         = (half_period == 16'd0) ? 16'd1 : half_period;
      tick_inc   = tick_count_ff + 16'd1;
      period_end = (tick_inc >= hp);

      if (phase_ff != PH_IDLE) begin
         tick_count_in = period_end ? 16'd0 : tick_inc;
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_item.command != CMD_NONE) begin
               active_command_in  = req_item.command;
               tick_count_in      = 16'd0;
               bit_count_in       = 5'd0;
               first_word_zero_in = 1'b0;
               phase_in           = PH_ENTER_HI;
               unique case (req_item.command)
                  CMD_READ_WORD: begin
                     current_address_in = ADDRESS_BITS'(req_item.address);
                     words_left_in      = 2'd1;
                  end
                  CMD_READ_MAC: begin
                     current_address_in = ADDRESS_BITS'(MAC_FIRST_WORD);
                     words_left_in      = 2'(MAC_WORDS);
                  end
                  default: begin
                     current_address_in = '0;
                     words_left_in      = 2'd2;
                  end
               endcase
            end
         end
         PH_ENTER_HI: begin
            if (period_end) phase_in = PH_ENTER_LO;
         end
         PH_ENTER_LO: begin
            if (period_end) begin
               bit_count_in = 5'd0;
               phase_in     = PH_SEND_HI;
            end
         end
         PH_SEND_HI: begin
            if (period_end) phase_in = PH_SEND_LO;
         end
         PH_SEND_LO: begin
            if (period_end) begin
               if (bit_count_ff + 5'd1 < 5'(FRAME_W)) begin
                  bit_count_in = bit_count_ff + 5'd1;
                  phase_in     = PH_SEND_HI;
               end else begin
                  bit_count_in = 5'd0;
                  phase_in     = PH_RECV_HI;
               end
            end
         end
         PH_RECV_HI: begin
            if (period_end) begin
               shift_word_in = {shift_word_ff[14:0], req_item.data_out_pin};
               phase_in      = PH_RECV_LO;
            end
         end
         PH_RECV_LO: begin
            if (period_end) begin
               if (bit_count_ff + 5'd1 < 5'(DATA_BITS)) begin
                  bit_count_in = bit_count_ff + 5'd1;
                  phase_in     = PH_RECV_HI;
               end else begin
                  bit_count_in = 5'd0;
                  phase_in     = PH_CLOSE_HI;
               end
            end
         end
         PH_CLOSE_HI: begin
            if (period_end) phase_in = PH_CLOSE_LO;
         end
         PH_CLOSE_LO: begin
            if (period_end) begin
               rsp.word_valid  = 1'b1;
               rsp.word_value  = shift_word_ff;
               rsp.word_number = current_address_ff[5:0];
               if (active_command_ff == CMD_READ_ID && current_address_ff == '0) begin
                  first_word_zero_in = (shift_word_ff == 16'd0);
               end
               words_left_in = words_left_ff - 2'd1;
               if (words_left_in != 2'd0) begin
                  current_address_in = current_address_ff + ADDRESS_BITS'(1);
                  phase_in           = PH_ENTER_HI;
               end else if (active_command_ff == CMD_READ_ID) begin
                  phase_in = PH_FINAL;
               end else begin
                  phase_in          = PH_IDLE;
                  rsp.sequence_done = 1'b1;
                  rsp.sequence_ok   = 1'b1;
               end
            end
         end
         PH_FINAL: begin
            if (period_end) begin
               phase_in          = PH_IDLE;
               rsp.sequence_done = 1'b1;
               rsp.sequence_ok   = !(first_word_zero_ff && shift_word_ff == 16'd0);
            end
         end
         default: begin
            phase_in      = PH_IDLE;
            tick_count_in = 16'd0;
         end
      endcase

      frame = 16'({READ_OPCODE, current_address_in});
      pos   = 4'(FRAME_W - 1) - bit_count_in[3:0];

      rsp.program_mode = (phase_in != PH_IDLE) && (phase_in != PH_FINAL);
      rsp.chip_select  = (phase_in >= PH_SEND_HI) && (phase_in <= PH_RECV_LO);
      rsp.serial_clock = (phase_in == PH_ENTER_HI) || (phase_in == PH_SEND_HI) ||
                         (phase_in == PH_RECV_HI) || (phase_in == PH_CLOSE_HI);
      if ((phase_in == PH_SEND_HI) || (phase_in == PH_SEND_LO)) begin
         rsp.data_in_pin = (bit_count_in < 5'(FRAME_W)) ? frame[pos] : frame[0];
      end
      rsp.busy_res = (phase_in != PH_IDLE);
   end

   assign rsp_item = rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         tick_count_ff      <= '0;
         bit_count_ff       <= '0;
         shift_word_ff      <= '0;
         words_left_ff      <= '0;
         current_address_ff <= '0;
         active_command_ff  <= '0;
         first_word_zero_ff <= 1'b0;
      end else if (step) begin
         phase_ff           <= phase_in;
         tick_count_ff      <= tick_count_in;
         bit_count_ff       <= bit_count_in;
         shift_word_ff      <= shift_word_in;
         words_left_ff      <= words_left_in;
         current_address_ff <= current_address_in;
         active_command_ff  <= active_command_in;
         first_word_zero_ff <= first_word_zero_in;
      end
   end

endmodule

`default_nettype wire
